// ===== hdl/ants_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ants_pkg: shared types for the ACK/NAK transfer sender
// Protocol state codes, action, send-code, status and outcome encodings,
// register indexes and the structs passed between the sender's modules.
// ----------------------------------------------------------------------------
package ants_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int COUNT_W     = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_OS_ERRORS    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TIMEOUTS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_NAKS         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PROTO_ERRORS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAIT_EOT_ACK     = 3'd4;

   localparam logic [COUNT_W-1:0] RST_MAX_OS_ERRORS    = 8'd3;
   localparam logic [COUNT_W-1:0] RST_MAX_TIMEOUTS     = 8'd3;
   localparam logic [COUNT_W-1:0] RST_MAX_NAKS         = 8'd3;
   localparam logic [COUNT_W-1:0] RST_MAX_PROTO_ERRORS = 8'd3;
   localparam logic               RST_WAIT_EOT_ACK     = 1'b0;

   typedef enum logic [4:0] {
      ST_IDLE      = 5'd0,
      ST_TX_UPL    = 5'd1,
      ST_RX_UPL    = 5'd2,
      ST_PREP_NAME = 5'd3,
      ST_TX_FIL    = 5'd4,
      ST_RX_FIL    = 5'd5,
      ST_TX_SOT    = 5'd6,
      ST_RX_SOT    = 5'd7,
      ST_PREP_DATA = 5'd8,
      ST_TX_DATA   = 5'd9,
      ST_RX_DATA   = 5'd10,
      ST_TX_EOT    = 5'd12,
      ST_RX_EOT    = 5'd13,
      ST_DONE      = 5'd14,
      ST_TX_CAN    = 5'd16,
      ST_TX_NAK    = 5'd18
   } state_type;

   typedef enum logic {
      CMD_START  = 1'b0,
      CMD_REPORT = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      OUT_OK        = 3'd0,
      OUT_OS_ERROR  = 3'd1,
      OUT_TIMEOUT   = 3'd2,
      OUT_CANCEL    = 3'd3,
      OUT_NAK       = 3'd4,
      OUT_UPL_REQ   = 3'd5,
      OUT_BAD_REPLY = 3'd6,
      OUT_OTHER_OS  = 3'd7
   } outcome_type;

   typedef enum logic [2:0] {
      ACT_SEND      = 3'd0,
      ACT_AWAIT     = 3'd1,
      ACT_PREP_NAME = 3'd2,
      ACT_PREP_DATA = 3'd3,
      ACT_DONE      = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      CODE_UPL  = 3'd0,
      CODE_FIL  = 3'd1,
      CODE_SOT  = 3'd2,
      CODE_DATA = 3'd3,
      CODE_EOT  = 3'd4,
      CODE_CAN  = 3'd5,
      CODE_NAK  = 3'd6
   } code_type;

   typedef enum logic [2:0] {
      STAT_OK          = 3'd0,
      STAT_REFUSED     = 3'd1,
      STAT_OS_LIMIT    = 3'd2,
      STAT_TMO_LIMIT   = 3'd3,
      STAT_NAK_LIMIT   = 3'd4,
      STAT_PROTO_LIMIT = 3'd5,
      STAT_ABORTED     = 3'd6
   } status_type;

   typedef struct packed {
      logic [COUNT_W-1:0] max_os_errors;
      logic [COUNT_W-1:0] max_timeouts;
      logic [COUNT_W-1:0] max_naks;
      logic [COUNT_W-1:0] max_proto_errors;
      logic               wait_eot_ack;
   } cfg_type;

   typedef struct packed {
      cmd_type     command;
      outcome_type outcome;
      logic        no_more_data;
   } req_type;

   typedef struct packed {
      logic               valid;
      action_type         action;
      code_type           send_code;
      logic [COUNT_W-1:0] packet_number;
      status_type         status;
   } res_type;

endpackage
`default_nettype wire

// ===== hdl/ants_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ants_csr: configuration registers
// Holds the error limits and the EOT acknowledge option, written through a
// plain write port. Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module ants_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [ants_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ants_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output ants_pkg::cfg_type                 cfg
);
   import ants_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_OS_ERRORS:    cfg_in.max_os_errors    = csr_wdata;
            CSR_MAX_TIMEOUTS:     cfg_in.max_timeouts     = csr_wdata;
            CSR_MAX_NAKS:         cfg_in.max_naks         = csr_wdata;
            CSR_MAX_PROTO_ERRORS: cfg_in.max_proto_errors = csr_wdata;
            CSR_WAIT_EOT_ACK:     cfg_in.wait_eot_ack     = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_os_errors    <= RST_MAX_OS_ERRORS;
         cfg_ff.max_timeouts     <= RST_MAX_TIMEOUTS;
         cfg_ff.max_naks         <= RST_MAX_NAKS;
         cfg_ff.max_proto_errors <= RST_MAX_PROTO_ERRORS;
         cfg_ff.wait_eot_ack     <= RST_WAIT_EOT_ACK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== hdl/ants_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ants_engine: protocol state and next-action logic
// Holds the protocol state, retry counters, packet counter and final status,
// and resolves one transaction per firing cycle into the next external action.
// ----------------------------------------------------------------------------
module ants_engine (
   input  logic              clock,
   input  logic              reset,
   input  ants_pkg::cfg_type cfg,
   input  logic              fire,
   input  ants_pkg::req_type req,
   output ants_pkg::res_type res
);
   import ants_pkg::*;

   typedef struct packed {
      action_type action;
      code_type   code;
      state_type  state;
   } land_type;

   state_type          state_ff, state_in;
   state_type          after_nak_ff, after_nak_in;
   logic [COUNT_W-1:0] os_cnt_ff, os_cnt_in;
   logic [COUNT_W-1:0] tmo_cnt_ff, tmo_cnt_in;
   logic [COUNT_W-1:0] nak_cnt_ff, nak_cnt_in;
   logic [COUNT_W-1:0] perr_cnt_ff, perr_cnt_in;
   logic [COUNT_W-1:0] pkt_ff, pkt_in;
   status_type         final_ff, final_in;

   state_type nxt_state;
   land_type  step;
   logic      res_valid;
   logic      os_fault;

   // Sequence order of the transfer when nothing goes wrong.
   function automatic state_type default_next(input state_type s, input state_type resume);
      state_type n;
      n = ST_DONE;
      case (s)
         ST_IDLE:      n = ST_TX_UPL;
         ST_TX_UPL:    n = ST_RX_UPL;
         ST_RX_UPL:    n = ST_PREP_NAME;
         ST_PREP_NAME: n = ST_TX_FIL;
         ST_TX_FIL:    n = ST_RX_FIL;
         ST_RX_FIL:    n = ST_TX_SOT;
         ST_TX_SOT:    n = ST_RX_SOT;
         ST_RX_SOT:    n = ST_PREP_DATA;
         ST_PREP_DATA: n = ST_TX_DATA;
         ST_TX_DATA:   n = ST_RX_DATA;
         ST_RX_DATA:   n = ST_PREP_DATA;
         ST_TX_EOT:    n = ST_RX_EOT;
         ST_TX_NAK:    n = resume;
         default:      n = ST_DONE;
      endcase
      return n;
   endfunction

   // The send state whose acknowledge is awaited in a given wait state.
   function automatic state_type send_state_of(input state_type s);
      state_type n;
      n = ST_IDLE;
      case (s)
         ST_RX_UPL:  n = ST_TX_UPL;
         ST_RX_FIL:  n = ST_TX_FIL;
         ST_RX_SOT:  n = ST_TX_SOT;
         ST_RX_DATA: n = ST_TX_DATA;
         ST_RX_EOT:  n = ST_TX_EOT;
         default:    n = ST_IDLE;
      endcase
      return n;
   endfunction

   // Action emitted when the sequence lands on a target state. Without the
   // EOT acknowledge option the EOT wait falls straight through to done.
   function automatic land_type land(input state_type target, input logic eot_ack);
      land_type l;
      l = '{ACT_DONE, CODE_UPL, ST_DONE};
      case (target)
         ST_IDLE, ST_TX_UPL: l = '{ACT_SEND, CODE_UPL, ST_TX_UPL};
         ST_TX_FIL:          l = '{ACT_SEND, CODE_FIL, ST_TX_FIL};
         ST_TX_SOT:          l = '{ACT_SEND, CODE_SOT, ST_TX_SOT};
         ST_TX_DATA:         l = '{ACT_SEND, CODE_DATA, ST_TX_DATA};
         ST_TX_EOT:          l = '{ACT_SEND, CODE_EOT, ST_TX_EOT};
         ST_TX_CAN:          l = '{ACT_SEND, CODE_CAN, ST_TX_CAN};
         ST_TX_NAK:          l = '{ACT_SEND, CODE_NAK, ST_TX_NAK};
         ST_RX_UPL, ST_RX_FIL, ST_RX_SOT, ST_RX_DATA:
            l = '{ACT_AWAIT, CODE_UPL, target};
         ST_RX_EOT: begin
            if (eot_ack) l = '{ACT_AWAIT, CODE_UPL, ST_RX_EOT};
         end
         ST_PREP_NAME:       l = '{ACT_PREP_NAME, CODE_UPL, ST_PREP_NAME};
         ST_PREP_DATA:       l = '{ACT_PREP_DATA, CODE_UPL, ST_PREP_DATA};
         default: ;
      endcase
      return l;
   endfunction

   always_comb begin
      after_nak_in = after_nak_ff;
      os_cnt_in    = os_cnt_ff;
      tmo_cnt_in   = tmo_cnt_ff;
      nak_cnt_in   = nak_cnt_ff;
      perr_cnt_in  = perr_cnt_ff;
      pkt_in       = pkt_ff;
      final_in     = final_ff;
      res_valid    = 1'b1;
      os_fault     = 1'b0;
      nxt_state    = default_next(state_ff, after_nak_ff);
      step         = '{ACT_DONE, CODE_UPL, ST_DONE};

      if (req.command == CMD_START) begin
         os_cnt_in   = '0;
         tmo_cnt_in  = '0;
         nak_cnt_in  = '0;
         perr_cnt_in = '0;
         pkt_in      = '0;
         final_in    = STAT_OK;
         step        = land(ST_TX_UPL, cfg.wait_eot_ack);
      end else begin
         case (state_ff)
            ST_TX_UPL, ST_TX_FIL, ST_TX_SOT, ST_TX_DATA, ST_TX_EOT, ST_TX_CAN,
            ST_TX_NAK: begin
               // Any failure of a send is treated as an OS error.
               if (req.outcome != OUT_OK) os_fault = 1'b1;
               else step = land(nxt_state, cfg.wait_eot_ack);
            end
            ST_PREP_NAME: step = land(nxt_state, cfg.wait_eot_ack);
            ST_PREP_DATA: begin
               if (req.no_more_data) step = land(ST_TX_EOT, cfg.wait_eot_ack);
               else step = land(nxt_state, cfg.wait_eot_ack);
            end
            ST_RX_UPL, ST_RX_FIL, ST_RX_SOT, ST_RX_DATA, ST_RX_EOT: begin
               case (req.outcome)
                  OUT_OK: begin
                     tmo_cnt_in  = '0;
                     nak_cnt_in  = '0;
                     perr_cnt_in = '0;
                     if (nxt_state == ST_PREP_DATA) pkt_in = pkt_ff + 8'd1;
                     step = land(nxt_state, cfg.wait_eot_ack);
                  end
                  OUT_OS_ERROR, OUT_OTHER_OS: os_fault = 1'b1;
                  OUT_TIMEOUT: begin
                     if (tmo_cnt_ff >= cfg.max_timeouts) begin
                        final_in = STAT_TMO_LIMIT;
                        step     = land(ST_TX_CAN, cfg.wait_eot_ack);
                     end else begin
                        tmo_cnt_in   = tmo_cnt_ff + 8'd1;
                        after_nak_in = send_state_of(state_ff);
                        step         = land(ST_TX_NAK, cfg.wait_eot_ack);
                     end
                  end
                  OUT_CANCEL: begin
                     final_in = STAT_ABORTED;
                     step     = '{ACT_DONE, CODE_UPL, ST_DONE};
                  end
                  OUT_NAK: begin
                     after_nak_in = send_state_of(state_ff);
                     if (nak_cnt_ff >= cfg.max_naks) begin
                        final_in = STAT_NAK_LIMIT;
                        step     = land(ST_TX_CAN, cfg.wait_eot_ack);
                     end else begin
                        nak_cnt_in = nak_cnt_ff + 8'd1;
                        step       = land(send_state_of(state_ff), cfg.wait_eot_ack);
                     end
                  end
                  default: begin
                     // An upload request while waiting on the UPL ack means the
                     // peer refuses; anywhere else it is just a bad reply.
                     if (req.outcome == OUT_UPL_REQ && state_ff == ST_RX_UPL) begin
                        final_in = STAT_REFUSED;
                        step     = land(ST_TX_CAN, cfg.wait_eot_ack);
                     end else begin
                        after_nak_in = state_ff;
                        if (perr_cnt_ff >= cfg.max_proto_errors) begin
                           final_in = STAT_PROTO_LIMIT;
                           step     = land(ST_TX_CAN, cfg.wait_eot_ack);
                        end else begin
                           perr_cnt_in = perr_cnt_ff + 8'd1;
                           step        = land(ST_TX_NAK, cfg.wait_eot_ack);
                        end
                     end
                  end
               endcase
            end
            default: res_valid = 1'b0;
         endcase

         // OS errors retry the current action until the limit, then finish
         // without a CAN.
         if (os_fault) begin
            if (os_cnt_ff >= cfg.max_os_errors) begin
               final_in = STAT_OS_LIMIT;
               step     = '{ACT_DONE, CODE_UPL, ST_DONE};
            end else begin
               os_cnt_in = os_cnt_ff + 8'd1;
               step      = land(state_ff, cfg.wait_eot_ack);
            end
         end
      end

      state_in = res_valid ? step.state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         after_nak_ff <= ST_IDLE;
         os_cnt_ff    <= '0;
         tmo_cnt_ff   <= '0;
         nak_cnt_ff   <= '0;
         perr_cnt_ff  <= '0;
         pkt_ff       <= '0;
         final_ff     <= STAT_OK;
      end else if (fire) begin
         state_ff     <= state_in;
         after_nak_ff <= after_nak_in;
         os_cnt_ff    <= os_cnt_in;
         tmo_cnt_ff   <= tmo_cnt_in;
         nak_cnt_ff   <= nak_cnt_in;
         perr_cnt_ff  <= perr_cnt_in;
         pkt_ff       <= pkt_in;
         final_ff     <= final_in;
      end
   end

   always_comb begin
      res.valid         = res_valid;
      res.action        = step.action;
      res.send_code     = step.code;
      res.packet_number = pkt_in;
      res.status        = (step.action == ACT_DONE) ? final_in : STAT_OK;
   end

endmodule
`default_nettype wire

// ===== hdl/ants_rsp_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ants_rsp_stage: result register
// Holds one finished result until the receiver takes it, and tells the
// engine whether a new result can be loaded in this cycle.
// ----------------------------------------------------------------------------
module ants_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  ants_pkg::res_type res,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic              out_free,
   output ants_pkg::res_type held
);
   import ants_pkg::*;

   logic    valid_ff, valid_in;
   res_type res_ff;

   assign out_free = ~valid_ff | ~rsp_stall;
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) res_ff <= res;
   end

   assign rsp_valid = valid_ff;
   assign held      = res_ff;

endmodule
`default_nettype wire

// ===== hdl/ack_nak_transfer_sender_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ack_nak_transfer_sender_unit: sender side of an ACK/NAK file transfer
// A request transaction either starts a transfer (command 0) or reports the
// outcome of the last action (command 1). Each request that the protocol
// answers yields one response transaction carrying the next action, the
// control code to send, the current packet number and the final status.
// Reports that arrive while idle or after the transfer is done give no
// response. Limits and the EOT acknowledge option sit on the csr_ port. The
// user must see that they are written only while no transaction is in flight;
// the block itself does not enforce this. An accepted request is loaded into
// the input register and then, through the next-action logic, into the result
// register that drives rsp_valid. The protocol state is updated in the same
// cycle as the result register is loaded, so while the response is not stalled
// a new request is taken every cycle and the sustained rate is one per clock.
// A stalled response holds the result register; the input register still
// takes one more request, and req_stall rises only when both are full.
// Synchronous reset returns to idle with counters cleared and the limits
// at their defaults (three retries each, no wait for the EOT acknowledge).
// ----------------------------------------------------------------------------
module ack_nak_transfer_sender_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic [2:0]                       req_outcome,
   input  logic                             req_no_more_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_action,
   output logic [2:0]                       rsp_send_code,
   output logic [ants_pkg::COUNT_W-1:0]     rsp_packet_number,
   output logic [2:0]                       rsp_status,
   input  logic                             csr_wr_en,
   input  logic [ants_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ants_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ants_pkg::*;

   cfg_type cfg;
   req_type s1_req_ff, s1_req_in;
   logic    s1_valid_ff, s1_valid_in;
   logic    accept, fire, load, out_free;
   res_type eng_res, held;

   assign fire      = s1_valid_ff & out_free;
   assign req_stall = s1_valid_ff & ~out_free;
   assign accept    = req_valid & ~req_stall;
   assign load      = fire & eng_res.valid;

   assign s1_valid_in = accept | (s1_valid_ff & ~fire);

   always_comb begin
      s1_req_in = s1_req_ff;
      if (accept) begin
         s1_req_in.command      = cmd_type'(req_command);
         s1_req_in.outcome      = outcome_type'(req_outcome);
         s1_req_in.no_more_data = req_no_more_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
   end

   ants_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ants_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .fire  (fire),
      .req   (s1_req_ff),
      .res   (eng_res)
   );

   ants_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .res       (eng_res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .out_free  (out_free),
      .held      (held)
   );

   assign rsp_action        = held.action;
   assign rsp_send_code     = held.send_code;
   assign rsp_packet_number = held.packet_number;
   assign rsp_status        = held.status;

   // The engine must not advance while its result has nowhere to go.
   a_no_fire_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !fire)
      else $error("engine advanced while the result register was stalled");

   // A start always answers with an UPL send and a cleared packet number.
   a_start_sends_upl: assert property (@(posedge clock) disable iff (reset)
      (fire && s1_req_ff.command == CMD_START) |=>
      (rsp_valid && rsp_action == ACT_SEND && rsp_send_code == CODE_UPL &&
       rsp_packet_number == 8'd0))
      else $error("start transaction did not produce an UPL send");

   // A transaction that the protocol ignores must not leave a response.
   a_ignored_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (fire && !eng_res.valid && !(rsp_valid && rsp_stall)) |=> !rsp_valid)
      else $error("response produced for an ignored transaction");

endmodule
`default_nettype wire
